/* sv/kms_pkg.sv */
package kms_pkg;

    localparam int STACK_DEPTH = 6;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_W       = CNT_W + 2;

    localparam int NUM_COLS    = 4;
    localparam int COL_W       = 2;
    localparam int ROW_IDX_W   = 2;
    localparam int ROW_W       = 4;
    localparam int STAGE_W     = 3;
    localparam int CODE_W      = 7;
    localparam int COL_SHIFT   = 4;

    // request kinds carried on tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // keys found on one odd-stage tick
    typedef struct packed {
        logic [NUM_COLS-1:0]  hit;
        logic [ROW_IDX_W-1:0] row;
    } kms_push_t;

    // outcome of a read request
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } kms_pop_t;

    // key code: upper bits column+1, low nibble row
    function automatic logic [CODE_W-1:0] kms_key_code(input logic [COL_W-1:0] col,
                                                       input logic [ROW_IDX_W-1:0] row);
        logic [CODE_W-1:0] col_part;
        col_part = CODE_W'(CODE_W'(col) + CODE_W'(1)) << COL_SHIFT;
        return col_part | CODE_W'(row);
    endfunction

endpackage

/* sv/keypad_matrix_scanner.sv */
// 4x4 key matrix scanner with a small last-in-first-out key stack. each request
// is either a scan tick or a key read, chosen by s_axis_tuser. a tick steps a
// 3-bit stage counter (wrapping after 7); the row is stage/2, an even stage
// drives that row one-hot, an odd stage samples the column bits from
// s_axis_tdata and pushes ((column+1)<<4)|row for each high column, column 0
// first. pushes beyond the stack depth (6) are dropped. a read pops the newest
// key, or returns key_valid = 0 when the stack is empty. every request gives
// exactly one result: row_drive, key_code and key_valid. no debouncing is done.
// throughput is one request per clock while m_axis_tready is high; a request
// passes the input register, then the result register, with the counter, row and stack
// update done in the single combinational pass between them.
module keypad_matrix_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] col_sample, [7:4] zero
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] row_drive, [10:4] key_code, [15:11] zero
    output logic        m_axis_tuser    // [0] key_valid
);
    import kms_pkg::*;

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                in_req_reg;
    logic [NUM_COLS-1:0] in_cols_reg;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ROW_W-1:0]    out_row_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic                out_key_valid_reg;

    logic                accept;
    logic                advance;
    logic                tick;
    logic                read;
    logic [ROW_W-1:0]    row_next;
    kms_push_t           push;
    kms_pop_t            pop;

    // the held request moves on whenever the result slot is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tick = advance && (in_req_reg == REQ_TICK);
    assign read = advance && (in_req_reg == REQ_READ);

    kms_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .cols     (in_cols_reg),
        .row_next (row_next),
        .push     (push)
    );

    kms_stack u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop_req (read),
        .push    (push),
        .pop     (pop)
    );

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg  <= s_axis_tuser;
            in_cols_reg <= s_axis_tdata[NUM_COLS-1:0];
        end
        if (advance)
        begin
            out_row_reg       <= row_next;
            out_code_reg      <= pop.code;
            out_key_valid_reg <= pop.valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_code_reg, out_row_reg};
    assign m_axis_tuser  = out_key_valid_reg;

endmodule

/* sv/kms_scan.sv */
module kms_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic [kms_pkg::NUM_COLS-1:0] cols,
    output logic [kms_pkg::ROW_W-1:0] row_next,
    output kms_pkg::kms_push_t        push
);
    import kms_pkg::*;

    logic [STAGE_W-1:0]   stage_reg;
    logic [STAGE_W-1:0]   stage_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_IDX_W-1:0] row_idx;
    logic [ROW_W-1:0]     row_onehot;
    logic                 odd_stage;

    always_comb
    begin
        stage_next = stage_reg + STAGE_W'(1);
        row_idx    = stage_next[STAGE_W-1:1];
        odd_stage  = stage_next[0];
        row_onehot = ROW_W'(1) << row_idx;
        row_next   = (tick && !odd_stage) ? row_onehot : row_reg;
        push.row   = row_idx;
        push.hit   = (tick && odd_stage) ? cols : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            row_reg   <= '0;
        end
        else if (tick)
        begin
            stage_reg <= stage_next;
            row_reg   <= row_next;
        end
    end

endmodule

/* sv/kms_stack.sv */
module kms_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_req,
    input  kms_pkg::kms_push_t push,
    output kms_pkg::kms_pop_t  pop
);
    import kms_pkg::*;

    logic [CODE_W-1:0] stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  top_pos;
    logic [POS_W-1:0]  pos [NUM_COLS];
    logic [POS_W-1:0]  fill;

    always_comb
    begin
        // slot each hit column lands in, column 0 first
        fill = POS_W'(count_reg);
        for (int c = 0; c < NUM_COLS; c++)
        begin
            pos[c] = fill;
            if (push.hit[c])
            begin
                fill = fill + POS_W'(1);
            end
        end

        top_pos    = count_reg - CNT_W'(1);
        pop.valid  = pop_req && (count_reg != '0);
        pop.code   = pop.valid ? stack_reg[top_pos[IDX_W-1:0]] : '0;

        count_next = count_reg;
        if (pop.valid)
        begin
            count_next = top_pos;
        end
        else if (fill > POS_W'(STACK_DEPTH))
        begin
            count_next = CNT_W'(STACK_DEPTH);
        end
        else
        begin
            count_next = fill[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries have no reset, only slots below the count are read
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if (push.hit[c] && (pos[c] == POS_W'(i)))
                begin
                    stack_reg[i] <= kms_key_code(COL_W'(c), push.row);
                end
            end
        end
    end

endmodule
